// ===== rtl/core/bie_pkg.sv =====
package bie_pkg;

	localparam int OPERATOR_DEPTH_DEF = 32;
	localparam int VALUE_DEPTH_DEF    = 32;
	localparam int VARIABLE_COUNT_DEF = 64;
	localparam int VAR_WORD_W         = 64;

	// token kinds on the input channel
	localparam logic [2:0] TOK_CONST = 3'd0;
	localparam logic [2:0] TOK_VAR   = 3'd1;
	localparam logic [2:0] TOK_NOT   = 3'd2;
	localparam logic [2:0] TOK_AND   = 3'd3;
	localparam logic [2:0] TOK_OR    = 3'd4;
	localparam logic [2:0] TOK_OPEN  = 3'd5;
	localparam logic [2:0] TOK_CLOSE = 3'd6;
	localparam logic [2:0] TOK_END   = 3'd7;

	localparam logic [2:0] ERR_NONE     = 3'd0;
	localparam logic [2:0] ERR_OPERAND  = 3'd1;
	localparam logic [2:0] ERR_PAREN    = 3'd2;
	localparam logic [2:0] ERR_OVERFLOW = 3'd3;
	localparam logic [2:0] ERR_LEFTOVER = 3'd4;

	// operator stack entries; the code doubles as the priority
	typedef enum logic [1:0] {
		OPC_OPEN = 2'd0,
		OPC_OR   = 2'd1,
		OPC_AND  = 2'd2,
		OPC_NOT  = 2'd3
	} opc_t;

	typedef struct packed {
		logic [2:0] operation;
		logic       const_bit;
		logic [5:0] var_index;
	} in_item_t;

	typedef struct packed {
		logic       result_bit;
		logic [2:0] error_code;
	} out_item_t;

	typedef struct packed {
		logic vpush;
		logic vpush_bit;
		logic opush;
		opc_t opush_code;
		logic pop;   // pop operator top and apply it to the value stack
		logic load;  // completes a pop, RAM read data valid
		logic clear;
	} stk_cmd_t;

	typedef struct packed {
		logic o_empty;
		logic o_full;
		logic v_empty;
		logic v_full;
		logic v_multi;
		opc_t otop;
		logic vtop;
	} stk_status_t;

endpackage

// ===== rtl/core/bie_ram.sv =====
module bie_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== rtl/core/bie_stacks.sv =====
module bie_stacks
	import bie_pkg::*;
#(
	parameter int OPERATOR_DEPTH = OPERATOR_DEPTH_DEF,
	parameter int VALUE_DEPTH    = VALUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  stk_cmd_t    cmd,
	output stk_status_t status
);

	localparam int OCW = $clog2(OPERATOR_DEPTH + 1);
	localparam int VCW = $clog2(VALUE_DEPTH + 1);
	localparam int OAW = (OPERATOR_DEPTH > 1) ? $clog2(OPERATOR_DEPTH) : 1;
	localparam int VAW = (VALUE_DEPTH > 1) ? $clog2(VALUE_DEPTH) : 1;

	// top entries live in registers, the RAMs hold everything below them
	logic [OCW-1:0] ocount_q;
	logic [VCW-1:0] vcount_q;
	opc_t           otop_q;
	logic           vtop_q;
	opc_t           pend_q;

	logic [OCW-1:0] o_minus1, o_minus2;
	logic [VCW-1:0] v_minus1, v_minus2;
	logic [1:0]     oram_rdata;
	logic           vram_rdata;
	logic           binary_pop;

	assign o_minus1 = ocount_q - OCW'(1);
	assign o_minus2 = ocount_q - OCW'(2);
	assign v_minus1 = vcount_q - VCW'(1);
	assign v_minus2 = vcount_q - VCW'(2);

	bie_ram #(.WIDTH(2), .DEPTH(OPERATOR_DEPTH)) u_oram (
		.clk   (clk),
		.we    (cmd.opush && (ocount_q != '0)),
		.waddr (o_minus1[OAW-1:0]),
		.wdata (otop_q),
		.raddr (o_minus2[OAW-1:0]),
		.rdata (oram_rdata)
	);

	bie_ram #(.WIDTH(1), .DEPTH(VALUE_DEPTH)) u_vram (
		.clk   (clk),
		.we    (cmd.vpush && (vcount_q != '0)),
		.waddr (v_minus1[VAW-1:0]),
		.wdata (vtop_q),
		.raddr (v_minus2[VAW-1:0]),
		.rdata (vram_rdata)
	);

	assign binary_pop = (pend_q == OPC_AND) || (pend_q == OPC_OR);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ocount_q <= '0;
			vcount_q <= '0;
		end else if (cmd.clear) begin
			ocount_q <= '0;
			vcount_q <= '0;
		end else begin
			if (cmd.opush) begin
				ocount_q <= ocount_q + OCW'(1);
			end else if (cmd.pop) begin
				ocount_q <= o_minus1;
			end
			if (cmd.vpush) begin
				vcount_q <= vcount_q + VCW'(1);
			end else if (cmd.load && binary_pop) begin
				vcount_q <= v_minus1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.opush) begin
			otop_q <= cmd.opush_code;
		end else if (cmd.load) begin
			otop_q <= opc_t'(oram_rdata);
		end
		if (cmd.pop) begin
			pend_q <= otop_q;
		end
		if (cmd.vpush) begin
			vtop_q <= cmd.vpush_bit;
		end else if (cmd.pop && (otop_q == OPC_NOT)) begin
			vtop_q <= ~vtop_q;
		end else if (cmd.load && binary_pop) begin
			vtop_q <= (pend_q == OPC_AND) ? (vtop_q & vram_rdata) : (vtop_q | vram_rdata);
		end
	end

	assign status.o_empty = (ocount_q == '0);
	assign status.o_full  = (ocount_q == OCW'(OPERATOR_DEPTH));
	assign status.v_empty = (vcount_q == '0);
	assign status.v_full  = (vcount_q == VCW'(VALUE_DEPTH));
	assign status.v_multi = (vcount_q > VCW'(1));
	assign status.otop    = otop_q;
	assign status.vtop    = vtop_q;

endmodule

// ===== rtl/core/boolean_infix_evaluator.sv =====
// Boolean infix evaluator: one token per input transaction (const, variable,
// NOT, AND, OR, open, close, end), evaluated on the fly on an operator stack
// and a value stack. Only the end token produces an output transaction:
// the expression value and an error code; the stacks are then emptied.
// Channels: in_valid/in_stall/in_data and out_valid/out_stall/out_data move
// a transaction when valid is high and stall is low. The variable vector is
// written on cfg_valid/cfg_ready/cfg_data; the user must write it only while
// the block is idle; the block itself does not enforce this. Const, variable
// and open tokens are taken without a stall. An operator token pops the
// operators that its priority allows and then pushes itself; close pops the
// operators above its open and then the open; end pops the remaining
// operators, with an extra check step when the final unwind hits an error,
// and registers the result in its last step. Each pop takes a check step and
// a load step because the stack RAMs have a registered read. in_stall is high
// while a token is being worked off. The output register frees the input
// side: tokens keep being taken while a result waits, but the next end token
// holds until the result is taken. Reset clears the stacks, the sticky error,
// the variable vector and the output valid.
module boolean_infix_evaluator
	import bie_pkg::*;
#(
	parameter int OPERATOR_DEPTH = OPERATOR_DEPTH_DEF,
	parameter int VALUE_DEPTH    = VALUE_DEPTH_DEF,
	parameter int VARIABLE_COUNT = VARIABLE_COUNT_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  in_item_t              in_data,
	output logic                  out_valid,
	input  logic                  out_stall,
	output out_item_t             out_data,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [VAR_WORD_W-1:0] cfg_data
);

	localparam int VIW = (VARIABLE_COUNT > 1) ? $clog2(VARIABLE_COUNT) : 1;

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_CHECK = 3'b010,
		ST_LOAD  = 3'b100
	} state_t;

	typedef enum logic [1:0] {
		MODE_OPER  = 2'd0,
		MODE_CLOSE = 2'd1,
		MODE_END   = 2'd2
	} mode_t;

	state_t                    state_q, state_d;
	mode_t                     mode_q, mode_d;
	opc_t                      prio_q, prio_d;
	logic [2:0]                err_q, err_d;
	logic                      last_open_q, last_open_d;
	logic                      load_open_q, load_open_d;
	logic [VARIABLE_COUNT-1:0] vars_q;
	logic                      out_valid_q, out_valid_d;
	out_item_t                 out_q, out_d;

	stk_cmd_t    cmd;
	stk_status_t st;

	logic       accept;
	logic       out_free;
	logic       var_bit;
	logic       can_pop;
	logic       operand_ok;
	logic [2:0] final_err;

	bie_stacks #(
		.OPERATOR_DEPTH (OPERATOR_DEPTH),
		.VALUE_DEPTH    (VALUE_DEPTH)
	) u_stacks (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.status (st)
	);

	assign in_stall  = (state_q != ST_IDLE);
	assign accept    = in_valid && (state_q == ST_IDLE);
	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign cfg_ready = 1'b1;

	// indexes at or above the variable count read as zero
	assign var_bit = ({1'b0, in_data.var_index} < 7'(VARIABLE_COUNT)) ?
		vars_q[in_data.var_index[VIW-1:0]] : 1'b0;

	// NOT is right-associative: an equal-priority NOT stays on the stack
	assign can_pop = !st.o_empty && (st.otop != OPC_OPEN) &&
		((st.otop > prio_q) || ((st.otop == prio_q) && (prio_q != OPC_NOT)));
	assign operand_ok = (st.otop == OPC_NOT) ? !st.v_empty : st.v_multi;

	always_comb begin
		if (err_q != ERR_NONE) begin
			final_err = err_q;
		end else if (st.v_empty) begin
			final_err = ERR_OPERAND;
		end else if (st.v_multi) begin
			final_err = ERR_LEFTOVER;
		end else begin
			final_err = ERR_NONE;
		end
	end

	always_comb begin
		state_d     = state_q;
		mode_d      = mode_q;
		prio_d      = prio_q;
		err_d       = err_q;
		last_open_d = last_open_q;
		load_open_d = load_open_q;
		out_valid_d = out_valid_q && out_stall;
		out_d       = out_q;
		cmd         = '0;

		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (in_data.operation == TOK_END) begin
						mode_d  = MODE_END;
						state_d = ST_CHECK;
					end else if (err_q == ERR_NONE) begin
						last_open_d = (in_data.operation == TOK_OPEN);
						case (in_data.operation)
							TOK_CONST, TOK_VAR: begin
								if (st.v_full) begin
									err_d = ERR_OVERFLOW;
								end else begin
									cmd.vpush     = 1'b1;
									cmd.vpush_bit = (in_data.operation == TOK_CONST) ?
										in_data.const_bit : var_bit;
								end
							end
							TOK_NOT, TOK_AND, TOK_OR: begin
								mode_d  = MODE_OPER;
								state_d = ST_CHECK;
								prio_d  = (in_data.operation == TOK_NOT) ? OPC_NOT :
									(in_data.operation == TOK_AND) ? OPC_AND : OPC_OR;
							end
							TOK_OPEN: begin
								if (st.o_full) begin
									err_d = ERR_OVERFLOW;
								end else begin
									cmd.opush      = 1'b1;
									cmd.opush_code = OPC_OPEN;
								end
							end
							default: begin
								// close; "()" with nothing inside is an error
								if (last_open_q) begin
									err_d = ERR_PAREN;
								end else begin
									mode_d  = MODE_CLOSE;
									state_d = ST_CHECK;
								end
							end
						endcase
					end
				end
			end

			ST_CHECK: begin
				load_open_d = 1'b0;
				case (mode_q)
					MODE_OPER: begin
						if (can_pop) begin
							if (operand_ok) begin
								cmd.pop = 1'b1;
								state_d = ST_LOAD;
							end else begin
								err_d   = ERR_OPERAND;
								state_d = ST_IDLE;
							end
						end else begin
							state_d = ST_IDLE;
							if (st.o_full) begin
								err_d = ERR_OVERFLOW;
							end else begin
								cmd.opush      = 1'b1;
								cmd.opush_code = prio_q;
							end
						end
					end
					MODE_CLOSE: begin
						if (st.o_empty) begin
							err_d   = ERR_PAREN;
							state_d = ST_IDLE;
						end else if (st.otop == OPC_OPEN) begin
							cmd.pop     = 1'b1;
							load_open_d = 1'b1;
							state_d     = ST_LOAD;
						end else if (operand_ok) begin
							cmd.pop = 1'b1;
							state_d = ST_LOAD;
						end else begin
							err_d   = ERR_OPERAND;
							state_d = ST_IDLE;
						end
					end
					default: begin
						if ((err_q == ERR_NONE) && !st.o_empty) begin
							if (st.otop == OPC_OPEN) begin
								err_d = ERR_PAREN;
							end else if (operand_ok) begin
								cmd.pop = 1'b1;
								state_d = ST_LOAD;
							end else begin
								err_d = ERR_OPERAND;
							end
						end else if (out_free) begin
							out_valid_d      = 1'b1;
							out_d.error_code = final_err;
							out_d.result_bit = (final_err == ERR_NONE) ? st.vtop : 1'b0;
							cmd.clear        = 1'b1;
							err_d            = ERR_NONE;
							last_open_d      = 1'b0;
							state_d          = ST_IDLE;
						end
					end
				endcase
			end

			ST_LOAD: begin
				cmd.load = 1'b1;
				state_d  = load_open_q ? ST_IDLE : ST_CHECK;
			end

			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			mode_q      <= MODE_OPER;
			err_q       <= ERR_NONE;
			last_open_q <= 1'b0;
			load_open_q <= 1'b0;
			out_valid_q <= 1'b0;
			vars_q      <= '0;
		end else begin
			state_q     <= state_d;
			mode_q      <= mode_d;
			err_q       <= err_d;
			last_open_q <= last_open_d;
			load_open_q <= load_open_d;
			out_valid_q <= out_valid_d;
			if (cfg_valid && cfg_ready) begin
				vars_q <= cfg_data[VARIABLE_COUNT-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		prio_q <= prio_d;
		out_q  <= out_d;
	end

endmodule
